// ===== src/black_run_segment_finder_macros.svh =====
// assertion macros for the black run segment finder
// used by the top level; no other dependencies
`ifndef BLACK_RUN_SEGMENT_FINDER_MACROS_SVH
`define BLACK_RUN_SEGMENT_FINDER_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold on every clock edge out of reset
`define BRSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequence that must hold in the cycle after the antecedent
`define BRSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BRSF_ASSERT(lbl, prop, msg)
`define BRSF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/brsf_pkg.sv =====
// shared constants, types and register codes of the black run segment finder
// no dependencies
`default_nettype none

package brsf_pkg;

    localparam int MAX_LINE_LENGTH = 1024;
    localparam int MAX_LINES       = 1024;
    localparam int COL_W           = $clog2(MAX_LINE_LENGTH);
    localparam int ROW_W           = $clog2(MAX_LINES);
    localparam int LEN_W           = 11;
    localparam int GAP_W           = 4;
    localparam int GAP_CNT_W       = GAP_W + 1;
    localparam int CFG_IDX_W       = 2;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

    localparam logic [LEN_W-1:0] LINE_LENGTH_RST = LEN_W'(1024);
    localparam logic [LEN_W-1:0] MIN_WIDTH_RST   = LEN_W'(6);
    localparam logic [GAP_W-1:0] MAX_GAP_RST     = GAP_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_LENGTH = 2'd0,
        REG_MIN_WIDTH   = 2'd1,
        REG_MAX_GAP     = 2'd2
    } cfg_reg_t;

    // closed run handed from front to back
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] first;
        logic [COL_W-1:0] last;
    } seg_rec_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ===== src/brsf_front.sv =====
// front part: column/row counting and run tracking, one pixel per cycle while accept is high
// depends on brsf_pkg
`default_nettype none

module brsf_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic                            pixel_black,
    input  wire logic                            frame_start,
    input  wire logic [brsf_pkg::LEN_W-1:0]      line_length,
    input  wire logic [brsf_pkg::GAP_W-1:0]      max_gap,
    output logic                                 rec_push,
    output brsf_pkg::seg_rec_t                   rec
);

    logic [brsf_pkg::COL_W-1:0]     col_reg, col_next;
    logic [brsf_pkg::ROW_W-1:0]     row_reg, row_next;
    logic                           open_reg, open_next;
    logic [brsf_pkg::COL_W-1:0]     first_reg, first_next;
    logic [brsf_pkg::COL_W-1:0]     last_reg, last_next;
    logic [brsf_pkg::GAP_CNT_W-1:0] gap_reg, gap_next;

    logic [brsf_pkg::LEN_W-1:0]     len_eff;
    logic                           line_end;
    logic                           emit;

    // line length zero acts as one, too large saturates
    always_comb
    begin
        if (line_length == '0)
            len_eff = brsf_pkg::LEN_W'(1);
        else if (line_length > brsf_pkg::LEN_W'(brsf_pkg::MAX_LINE_LENGTH))
            len_eff = brsf_pkg::LEN_W'(brsf_pkg::MAX_LINE_LENGTH);
        else
            len_eff = line_length;
    end

    always_comb
    begin
        logic [brsf_pkg::COL_W-1:0]     col_c;
        logic [brsf_pkg::ROW_W-1:0]     row_c;
        logic                           open_c;
        logic [brsf_pkg::COL_W-1:0]     first_c;
        logic [brsf_pkg::COL_W-1:0]     last_c;
        logic [brsf_pkg::GAP_CNT_W-1:0] gap_c;

        col_c   = frame_start ? '0   : col_reg;
        row_c   = frame_start ? '0   : row_reg;
        open_c  = frame_start ? 1'b0 : open_reg;
        first_c = frame_start ? '0   : first_reg;
        last_c  = frame_start ? '0   : last_reg;
        gap_c   = frame_start ? '0   : gap_reg;

        emit = 1'b0;
        rec.row   = row_c;
        rec.first = first_c;
        rec.last  = last_c;

        if (pixel_black)
        begin
            if (!open_c)
            begin
                open_c  = 1'b1;
                first_c = col_c;
            end
            last_c = col_c;
            gap_c  = '0;
        end
        else if (open_c)
        begin
            gap_c = gap_c + 1'b1;
            if (gap_c > {1'b0, max_gap})
            begin
                // gap too wide: close here
                emit      = 1'b1;
                rec.first = first_c;
                rec.last  = last_c;
                open_c    = 1'b0;
                first_c   = '0;
                last_c    = '0;
                gap_c     = '0;
            end
        end

        line_end = ({1'b0, col_c} + 1'b1) >= len_eff;

        if (line_end)
        begin
            if (open_c)
            begin
                emit      = 1'b1;
                rec.first = first_c;
                rec.last  = last_c;
                open_c    = 1'b0;
                first_c   = '0;
                last_c    = '0;
                gap_c     = '0;
            end
            col_next = '0;
            row_next = (row_c == brsf_pkg::ROW_W'(brsf_pkg::MAX_LINES - 1)) ? '0
                                                                           : row_c + 1'b1;
        end
        else
        begin
            col_next = col_c + 1'b1;
            row_next = row_c;
        end

        open_next  = open_c;
        first_next = first_c;
        last_next  = last_c;
        gap_next   = gap_c;
    end

    assign rec_push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            open_reg  <= 1'b0;
            first_reg <= '0;
            last_reg  <= '0;
            gap_reg   <= '0;
        end
        else if (accept)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            open_reg  <= open_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            gap_reg   <= gap_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/brsf_queue.sv =====
// short queue of closed runs between front and back
// depends on brsf_pkg
`default_nettype none

module brsf_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire brsf_pkg::seg_rec_t  push_rec,
    input  wire logic                pop,
    output brsf_pkg::seg_rec_t       pop_rec,
    output brsf_pkg::q_status_t      status
);

    brsf_pkg::seg_rec_t            mem_reg [brsf_pkg::QUEUE_DEPTH];
    logic [brsf_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [brsf_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [brsf_pkg::QPTR_W:0]     count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign status.full  = (count_reg == (brsf_pkg::QPTR_W+1)'(brsf_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_rec      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/brsf_back.sv =====
// back part: width filter, center computation and result register
// depends on brsf_pkg
`default_nettype none

module brsf_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire brsf_pkg::seg_rec_t            q_rec,
    output logic                               q_pop,
    input  wire logic [brsf_pkg::LEN_W-1:0]    min_width,
    input  wire logic                          out_pop,
    output logic                               out_valid,
    output logic [brsf_pkg::ROW_W-1:0]         seg_row,
    output logic [brsf_pkg::COL_W-1:0]         seg_first,
    output logic [brsf_pkg::COL_W-1:0]         seg_last,
    output logic [brsf_pkg::COL_W-1:0]         seg_center
);

    logic                         valid_reg, valid_next;
    logic [brsf_pkg::ROW_W-1:0]   row_reg;
    logic [brsf_pkg::COL_W-1:0]   first_reg;
    logic [brsf_pkg::COL_W-1:0]   last_reg;
    logic [brsf_pkg::COL_W-1:0]   center_reg;
    logic [brsf_pkg::LEN_W-1:0]   width;
    logic [brsf_pkg::COL_W:0]     sum;
    logic                         wide_enough;
    logic                         load;
    logic                         taken;

    assign width       = {1'b0, q_rec.last} - {1'b0, q_rec.first} + 1'b1;
    assign sum         = {1'b0, q_rec.first} + {1'b0, q_rec.last};
    assign wide_enough = width >= min_width;
    assign taken       = out_pop && valid_reg;
    assign q_pop       = !q_empty && (!valid_reg || taken);
    assign load        = q_pop && wide_enough;

    // narrow runs are dropped as they leave the queue
    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
            valid_next = wide_enough;
        else if (taken)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg    <= q_rec.row;
            first_reg  <= q_rec.first;
            last_reg   <= q_rec.last;
            center_reg <= sum[brsf_pkg::COL_W:1];
        end
    end

    assign out_valid  = valid_reg;
    assign seg_row    = row_reg;
    assign seg_first  = first_reg;
    assign seg_last   = last_reg;
    assign seg_center = center_reg;

endmodule

`default_nettype wire

// ===== src/black_run_segment_finder.sv =====
// black run segment finder: a run closed by an accepted pixel request goes through the run queue
// and then the result register onto the result ports, when the queue and result register are free
// throughput: one pixel request per cycle; input stalls only while the 4-entry run queue is full
// results leave at up to one per cycle through a single result register
// configuration writes take effect in the cycle after the write; cfg_ready is always high
// reset (rst_n, async, active low) clears counters, open run, queue and result valid
// and loads line_length 1024, min_width 6, max_gap 3
`default_nettype none

`include "black_run_segment_finder_macros.svh"

module black_run_segment_finder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // pixel side
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              pixel_black,
    input  wire logic                              frame_start,
    // result side
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [brsf_pkg::ROW_W-1:0]             seg_row,
    output logic [brsf_pkg::COL_W-1:0]             seg_first,
    output logic [brsf_pkg::COL_W-1:0]             seg_last,
    output logic [brsf_pkg::COL_W-1:0]             seg_center,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [brsf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [brsf_pkg::LEN_W-1:0]        cfg_data
);

    // configuration registers
    logic [brsf_pkg::LEN_W-1:0]   line_length_reg, line_length_next;
    logic [brsf_pkg::LEN_W-1:0]   min_width_reg, min_width_next;
    logic [brsf_pkg::GAP_W-1:0]   max_gap_reg, max_gap_next;

    // front to queue
    logic                         accept;
    logic                         rec_push;
    brsf_pkg::seg_rec_t           rec_in;

    // queue to back
    brsf_pkg::seg_rec_t           rec_out;
    brsf_pkg::q_status_t          q_status;
    logic                         q_pop;
    logic                         out_valid;

    assign cfg_ready = 1'b1;

    // register writes; indexes beyond the list are ignored
    always_comb
    begin
        line_length_next = line_length_reg;
        min_width_next   = min_width_reg;
        max_gap_next     = max_gap_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                brsf_pkg::REG_LINE_LENGTH: line_length_next = cfg_data;
                brsf_pkg::REG_MIN_WIDTH:   min_width_next   = cfg_data;
                brsf_pkg::REG_MAX_GAP:     max_gap_next     = cfg_data[brsf_pkg::GAP_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= brsf_pkg::LINE_LENGTH_RST;
            min_width_reg   <= brsf_pkg::MIN_WIDTH_RST;
            max_gap_reg     <= brsf_pkg::MAX_GAP_RST;
        end
        else
        begin
            line_length_reg <= line_length_next;
            min_width_reg   <= min_width_next;
            max_gap_reg     <= max_gap_next;
        end
    end

    // the front stalls only when the queue cannot take another closed run
    assign full   = q_status.full;
    assign accept = push && !full;

    brsf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel_black (pixel_black),
        .frame_start (frame_start),
        .line_length (line_length_reg),
        .max_gap     (max_gap_reg),
        .rec_push    (rec_push),
        .rec         (rec_in)
    );

    // decouples run tracking from the width filter and result register
    brsf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (rec_push),
        .push_rec (rec_in),
        .pop      (q_pop),
        .pop_rec  (rec_out),
        .status   (q_status)
    );

    brsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_status.empty),
        .q_rec      (rec_out),
        .q_pop      (q_pop),
        .min_width  (min_width_reg),
        .out_pop    (pop),
        .out_valid  (out_valid),
        .seg_row    (seg_row),
        .seg_first  (seg_first),
        .seg_last   (seg_last),
        .seg_center (seg_center)
    );

    assign empty = !out_valid;

    // a reported run never runs backwards
    `BRSF_ASSERT(a_order, !empty |-> (seg_last >= seg_first), "seg_last below seg_first")
    // center lies within the run
    `BRSF_ASSERT(a_center, !empty |-> (seg_center >= seg_first && seg_center <= seg_last), "bad center")
    // a new result can only come out of a queued run
    `BRSF_ASSERT(a_source, $fell(empty) |-> $past(!q_status.empty), "result without queued run")

endmodule

`default_nettype wire
